// ===== hdl/vni_pkg.sv =====
// vni_pkg: shared constants, register indexes and the control/status structs
// used between the value noise controller and its datapath. No dependencies.
`default_nettype none

package vni_pkg;

	localparam int SEG_W      = 7;   // samples_per_segment register width
	localparam int LEN_W      = 16;  // total_length register width
	localparam int IDX_W      = 16;  // sample_index width
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int FRAC_W     = 16;  // Q0.16 position and easing
	localparam int RECIP_W    = FRAC_W + 1;  // floor(65536 / f) needs 17 bits for f = 1

	localparam logic [CFG_ADDR_W-1:0] REG_SEG_LEN   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_LEN = 2'd1;

	localparam logic [SEG_W-1:0] SEG_RESET = 7'd30;
	localparam logic [LEN_W-1:0] LEN_RESET = 16'd1024;

	// 3.0 in Q2.16
	localparam logic [FRAC_W+1:0] EASE_THREE = 18'd196608;

	typedef struct packed {
		logic             load_prev;
		logic             load_seg;
		logic             div_start;
		logic             issue;
		logic             last;
		logic             done;
		logic [IDX_W-1:0] index;
		logic [SEG_W-1:0] seg_len;
	} vni_cmd_t;

	typedef struct packed {
		logic adv;
		logic div_done;
	} vni_stat_t;

endpackage

`default_nettype wire

// ===== hdl/vni_recip_div.sv =====
// vni_recip_div: restoring divider, one quotient bit per cycle, that forms
// floor(65536 / f) and 65536 mod f for the position step. Uses vni_pkg.
`default_nettype none

module vni_recip_div
	import vni_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SEG_W-1:0]   divisor,
	output logic                    done,
	output logic [RECIP_W-1:0]      quot,
	output logic [SEG_W-1:0]        rem
);

	localparam int CNT_W = $clog2(RECIP_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SEG_W-1:0] rem_q;
	logic [RECIP_W-1:0] quot_q;

	logic [SEG_W:0] shifted;
	logic [SEG_W:0] diff;
	logic           ge;

	// dividend is 2^16: only its top bit is set
	assign shifted = {rem_q, (cnt_q == CNT_W'(RECIP_W - 1))};
	assign ge      = shifted >= {1'b0, divisor};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(RECIP_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SEG_W-1:0] : shifted[SEG_W-1:0];
			quot_q <= {quot_q[RECIP_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== hdl/vni_datapath.sv =====
// vni_datapath: point registers, position accumulator and the easing and
// blend pipeline with its output register. Uses vni_pkg and vni_recip_div.
`default_nettype none

module vni_datapath
	import vni_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic signed [SAMPLE_WIDTH-1:0] point_value,
	input  wire vni_cmd_t                       cmd,
	output vni_stat_t                           stat,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic [IDX_W-1:0]                    sample_index,
	output logic                                last_of_run,
	output logic                                sequence_done
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int DW = SW + 1;           // point difference
	localparam int PW = SW + FRAC_W + 2;  // s * d product

	logic [RECIP_W-1:0] quot;
	logic [SEG_W-1:0]   rem;
	logic               div_done;
	logic               adv;

	vni_recip_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (cmd.seg_len),
		.done    (div_done),
		.quot    (quot),
		.rem     (rem)
	);

	// segment state
	logic signed [SW-1:0] prev_q;
	logic signed [SW-1:0] a_q;
	logic signed [DW-1:0] d_q;
	logic [FRAC_W-1:0]    t_q;
	logic [SEG_W-1:0]     r_q;

	logic [SEG_W:0]       r_sum;
	logic                 wrap;
	logic [SEG_W:0]       r_nxt;
	logic [RECIP_W-1:0]   t_sum;

	// t = x * 65536 / f stepped as quotient plus carried remainder
	assign r_sum = {1'b0, r_q} + {1'b0, rem};
	assign wrap  = r_sum >= {1'b0, cmd.seg_len};
	assign r_nxt = wrap ? r_sum - {1'b0, cmd.seg_len} : r_sum;
	assign t_sum = {1'b0, t_q} + quot + RECIP_W'(wrap);

	always_ff @(posedge clk) begin
		if (cmd.load_prev) begin
			prev_q <= point_value;
		end
		if (cmd.load_seg) begin
			a_q    <= prev_q;
			d_q    <= DW'(point_value) - DW'(prev_q);
			prev_q <= point_value;
			t_q    <= '0;
			r_q    <= '0;
		end else if (cmd.issue) begin
			t_q <= t_sum[FRAC_W-1:0];
			r_q <= r_nxt[SEG_W-1:0];
		end
	end

	// pipeline: s1 position, s2 t^2 and 3-2t, s3 ease, s4 blend product
	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;

	logic [FRAC_W-1:0]      t_s1;
	logic [FRAC_W-1:0]      t2_s2;
	logic [FRAC_W+1:0]      w_s2;
	logic [FRAC_W-1:0]      s_s3;
	logic signed [PW-1:0]   p_s4;

	logic signed [SW-1:0]   a_s1, a_s2, a_s3, a_s4;
	logic signed [DW-1:0]   d_s1, d_s2, d_s3;
	logic [IDX_W-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic                   last_s1, last_s2, last_s3, last_s4;
	logic                   done_s1, done_s2, done_s3, done_s4;

	logic [2*FRAC_W-1:0]    tt;
	logic [2*FRAC_W+1:0]    tw;
	logic signed [FRAC_W:0] s_ext;
	logic signed [PW-1:0]   blend;

	logic signed [SW-1:0]   sample_q;
	logic [IDX_W-1:0]       index_q;
	logic                   last_q, done_q;

	assign adv   = !out_valid_q || out_ready;
	assign tt    = t_s1 * t_s1;
	assign tw    = t2_s2 * w_s2;
	assign s_ext = $signed({1'b0, s_s3});
	assign blend = PW'(a_s4) + (p_s4 >>> FRAC_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_q;
			a_s1    <= a_q;
			d_s1    <= d_q;
			idx_s1  <= cmd.index;
			last_s1 <= cmd.last;
			done_s1 <= cmd.done;

			t2_s2   <= tt[2*FRAC_W-1:FRAC_W];
			w_s2    <= EASE_THREE - (FRAC_W+2)'({t_s1, 1'b0});
			a_s2    <= a_s1;
			d_s2    <= d_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;

			// ease stays below one, so the upper bits are zero
			s_s3    <= tw[2*FRAC_W-1:FRAC_W];
			a_s3    <= a_s2;
			d_s3    <= d_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			done_s3 <= done_s2;

			p_s4    <= s_ext * d_s3;
			a_s4    <= a_s3;
			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
			done_s4 <= done_s3;

			// arithmetic shift floors toward minus infinity
			sample_q <= blend[SW-1:0];
			index_q  <= idx_s4;
			last_q   <= last_s4;
			done_q   <= done_s4;
		end
	end

	assign stat.adv      = adv;
	assign stat.div_done = div_done;

	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign sample_index  = index_q;
	assign last_of_run   = last_q;
	assign sequence_done = done_q;

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> r_q < cmd.seg_len)
		else $error("position remainder not below segment length");

	a_pipe_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && adv |=> out_valid_q)
		else $error("sample lost between blend stage and output");

endmodule

`default_nettype wire

// ===== hdl/vni_ctrl.sv =====
// vni_ctrl: configuration registers, sequence counters and the state machine
// that sequences divide and sample issue. Uses vni_pkg.
`default_nettype none

module vni_ctrl
	import vni_pkg::*;
#(
	parameter int MAX_SEGMENT = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_ADDR_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	input  wire logic                  restart,
	output logic                       in_ready,
	output vni_cmd_t                   cmd,
	input  wire vni_stat_t             stat
);

	localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		RUN
	} state_t;

	state_t                 state_q;
	logic [SEG_W-1:0]       seg_cfg_q;
	logic [LEN_W-1:0]       len_cfg_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [SEG_W-1:0]       x_q;
	logic                   have_prev_q;
	logic                   finished_q;
	logic                   recip_ok_q;

	logic [SEG_W-1:0]       seg_len;
	logic [LEN_W-1:0]       len_eff;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [CMP_W-1:0]       count_ext;
	logic                   accept;
	logic                   start_seg;
	logic                   reached;
	logic                   issue;
	logic                   done;
	logic                   last;

	always_comb begin
		if (seg_cfg_q == '0) begin
			seg_len = SEG_W'(1);
		end else if (seg_cfg_q > SEG_W'(MAX_SEGMENT)) begin
			seg_len = SEG_W'(MAX_SEGMENT);
		end else begin
			seg_len = seg_cfg_q;
		end
	end

	assign len_eff   = (len_cfg_q == '0) ? LEN_W'(1) : len_cfg_q;
	assign count_inc = count_q + 1'b1;
	assign count_ext = CMP_W'(count_q);
	assign reached   = count_ext >= CMP_W'(len_eff);

	assign accept    = in_valid && (state_q == IDLE);
	assign start_seg = accept && !restart && !finished_q && have_prev_q && !reached;
	assign issue     = (state_q == RUN) && stat.adv;
	assign done      = CMP_W'(count_inc) >= CMP_W'(len_eff);
	assign last      = done || (x_q == seg_len - 1'b1);

	assign in_ready = (state_q == IDLE);

	assign cmd.load_prev = accept && (restart || (!finished_q && !have_prev_q));
	assign cmd.load_seg  = start_seg;
	assign cmd.div_start = start_seg && !recip_ok_q;
	assign cmd.issue     = issue;
	assign cmd.last      = last;
	assign cmd.done      = done;
	assign cmd.index     = count_ext[IDX_W-1:0];
	assign cmd.seg_len   = seg_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			seg_cfg_q   <= SEG_RESET;
			len_cfg_q   <= LEN_RESET;
			count_q     <= '0;
			x_q         <= '0;
			have_prev_q <= 1'b0;
			finished_q  <= 1'b0;
			recip_ok_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_SEG_LEN: begin
						seg_cfg_q  <= cfg_wdata[SEG_W-1:0];
						recip_ok_q <= 1'b0;
					end
					REG_TOTAL_LEN: begin
						len_cfg_q <= cfg_wdata[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				IDLE: begin
					if (accept) begin
						if (restart) begin
							count_q     <= '0;
							finished_q  <= 1'b0;
							have_prev_q <= 1'b1;
						end else if (!finished_q) begin
							if (!have_prev_q) begin
								have_prev_q <= 1'b1;
							end else if (reached) begin
								finished_q <= 1'b1;
							end else begin
								x_q     <= '0;
								state_q <= recip_ok_q ? RUN : DIV;
							end
						end
					end
				end
				DIV: begin
					if (stat.div_done) begin
						recip_ok_q <= 1'b1;
						state_q    <= RUN;
					end
				end
				RUN: begin
					if (issue) begin
						count_q <= count_inc;
						x_q     <= x_q + 1'b1;
						if (done) begin
							finished_q <= 1'b1;
						end
						if (last) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		issue && last |=> state_q == IDLE)
		else $error("run did not end after its last sample");

	a_done_sets_finished: assert property (@(posedge clk) disable iff (!arst_n)
		issue && done |=> finished_q)
		else $error("sequence end not recorded");

	a_run_needs_recip: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RUN |-> recip_ok_q)
		else $error("samples issued without a valid position step");

endmodule

`default_nettype wire

// ===== hdl/value_noise_interpolator_unit.sv =====
// value_noise_interpolator_unit: top level of the smoothstep value noise block.
// Depends on vni_pkg, vni_ctrl, vni_datapath and vni_recip_div.
`default_nettype none

// A point that starts a segment occupies the block while the controller takes
// the request and issues samples_per_segment samples (fewer when the sequence
// ends inside the segment), one sample per cycle while the output register is
// empty or out_ready is high. After reset or a write of samples_per_segment,
// the first segment also waits for the bit-serial divider that forms the
// position step 65536 / f; the step is kept for later segments. Points that
// emit nothing (restart, first point, finished sequence) leave the controller
// idle. Samples pass the easing multipliers and the output register, which
// lets the next point be taken while the last sample still waits for out_ready.
module value_noise_interpolator_unit
	import vni_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int MAX_SEGMENT  = 64,
	parameter int COUNT_WIDTH  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write_en,
	input  wire logic [CFG_ADDR_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] point_value,
	input  wire logic                           restart,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic [IDX_W-1:0]                    sample_index,
	output logic                                last_of_run,
	output logic                                sequence_done
);

	vni_cmd_t  cmd;
	vni_stat_t stat;

	vni_ctrl #(
		.MAX_SEGMENT (MAX_SEGMENT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.restart      (restart),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	vni_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.point_value   (point_value),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.sample        (sample),
		.sample_index  (sample_index),
		.last_of_run   (last_of_run),
		.sequence_done (sequence_done)
	);

endmodule

`default_nettype wire
